[hw/rtl/lpt_pkg.sv]
package lpt_pkg;

  // table geometry
  localparam int CAPACITY   = 16;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int AGE_W      = IDX_W;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int PAGE_W     = 20;
  localparam int ADDR_W     = 32;
  localparam int OP_W       = 3;
  localparam int SLOT_W     = 4;
  localparam int LCNT_W     = 5;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // request codes
  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
  localparam logic [OP_W-1:0] OP_PROBE      = 3'd2;
  localparam logic [OP_W-1:0] OP_DISCARD    = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH_PAGE = 3'd4;
  localparam logic [OP_W-1:0] OP_FLUSH_ALL  = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] vaddr;
    logic [PAGE_W-1:0] page_number;
  } lpt_in_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
    logic              page_loaded;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_page;
    logic              writeback;
    logic [PAGE_W-1:0] writeback_page;
    logic [LCNT_W-1:0] loaded_count;
    logic              last;
  } lpt_out_t;

  // broadcast to every cell; action flags are already qualified
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              wr;
    logic              touch;
    logic              load;
    logic              evict;
    logic              discard;
    logic              clean_hit;
    logic              flush;
    logic [AGE_W-1:0]  hit_age;
    logic [AGE_W-1:0]  evict_age;
    logic [AGE_W-1:0]  flush_age;
  } lpt_cmd_t;

  // per-cell status back to the controller
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AGE_W-1:0]  rec;
    logic [PAGE_W-1:0] page;
    logic              match;
    logic              evict_sel;
    logic              target;
    logic              flush_hit;
    logic              younger_dirty;
  } lpt_cell_st_t;

endpackage

[hw/rtl/lpt_cell.sv]
module lpt_cell
  import lpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lpt_cmd_t     cmd,
  input  logic         free_in,
  output logic         free_out,
  output lpt_cell_st_t st
);

  logic              valid_r, valid_nxt;
  logic              dirty_r, dirty_nxt;
  logic [AGE_W-1:0]  rec_r, rec_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic              match, evict_sel, free_here, target;

  // local compares
  assign match     = valid_r && (page_r == cmd.page);
  assign evict_sel = cmd.evict && valid_r && (rec_r == cmd.evict_age);
  assign free_here = !valid_r || evict_sel;
  assign target    = cmd.load && free_here && !free_in;
  // pass the lowest-free token to the next cell
  assign free_out  = free_in || free_here;

  assign st.valid         = valid_r;
  assign st.dirty         = dirty_r;
  assign st.rec           = rec_r;
  assign st.page          = page_r;
  assign st.match         = match;
  assign st.evict_sel     = evict_sel;
  assign st.target        = target;
  assign st.flush_hit     = valid_r && dirty_r && (rec_r == cmd.flush_age);
  assign st.younger_dirty = valid_r && dirty_r && (rec_r < cmd.flush_age);

  // apply the broadcast action to this entry
  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    rec_nxt   = rec_r;
    page_nxt  = page_r;
    if (cmd.touch) begin
      if (match) begin
        rec_nxt   = '0;
        dirty_nxt = dirty_r || cmd.wr;
      end else if (valid_r && (rec_r < cmd.hit_age)) begin
        rec_nxt = rec_r + 1'b1;
      end
    end else if (cmd.load) begin
      if (target) begin
        valid_nxt = 1'b1;
        page_nxt  = cmd.page;
        dirty_nxt = cmd.wr;
        rec_nxt   = '0;
      end else if (evict_sel) begin
        valid_nxt = 1'b0;
        dirty_nxt = 1'b0;
        rec_nxt   = '0;
      end else if (valid_r) begin
        rec_nxt = rec_r + 1'b1;
      end
    end else if (cmd.discard) begin
      if (match) begin
        valid_nxt = 1'b0;
        dirty_nxt = 1'b0;
        rec_nxt   = '0;
      end else if (valid_r && (rec_r > cmd.hit_age)) begin
        rec_nxt = rec_r - 1'b1;
      end
    end else if (cmd.clean_hit) begin
      if (match) begin
        dirty_nxt = 1'b0;
      end
    end else if (cmd.flush) begin
      if (st.flush_hit) begin
        dirty_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
      rec_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      rec_r   <= rec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

[hw/rtl/lru_page_table.sv]
// LRU page table: up to sixteen resident pages, each in a cell of a row that
// compares, ages and updates its own entry. A request is registered in the idle
// state and resolved by all cells in the exec state, and every request but
// flush-all gives one word. Flush-all sweeps the ages from oldest to newest, one
// age per cycle while the output register is free, and gives one word per dirty
// page (or one empty word). A word that is not taken holds the table until the
// output register frees. No clearing pass after reset.
module lru_page_table
  import lpt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lpt_in_t          in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output lpt_out_t         out_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   req_op_r;
  logic [PAGE_W-1:0] req_page_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CFG_W-1:0]  cap_r;
  logic [AGE_W-1:0]  age_r, age_nxt;
  logic              out_valid_r;
  lpt_out_t          out_word_r;

  lpt_cmd_t          cmd;
  lpt_cell_st_t      st [CAPACITY];
  logic [CAPACITY:0] free_chain;

  logic              out_free, exec_go, flush_go, is_acc, emit;
  logic [CNT_W-1:0]  cap_eff;
  lpt_out_t          res;

  logic              hit_any, hit_dirty, ev_dirty, any_dirty, fl_any, young_any;
  logic [IDX_W-1:0]  hit_idx, tgt_idx, fl_idx;
  logic [AGE_W-1:0]  hit_rec;
  logic [PAGE_W-1:0] ev_page, fl_page;

  // row of cells, lowest-free token runs from cell 0 upward
  assign free_chain[0] = 1'b0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    lpt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .free_in  (free_chain[g]),
      .free_out (free_chain[g+1]),
      .st       (st[g])
    );
  end

  // gather cell status
  always_comb begin
    hit_any   = 1'b0;
    hit_dirty = 1'b0;
    ev_dirty  = 1'b0;
    any_dirty = 1'b0;
    fl_any    = 1'b0;
    young_any = 1'b0;
    hit_idx   = '0;
    tgt_idx   = '0;
    fl_idx    = '0;
    hit_rec   = '0;
    ev_page   = '0;
    fl_page   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (st[i].match) begin
        hit_any   = 1'b1;
        hit_dirty = hit_dirty | st[i].dirty;
        hit_idx   = hit_idx | IDX_W'(i);
        hit_rec   = hit_rec | st[i].rec;
      end
      if (st[i].evict_sel) begin
        ev_dirty = ev_dirty | st[i].dirty;
        ev_page  = ev_page | st[i].page;
      end
      if (st[i].target) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
      if (st[i].flush_hit) begin
        fl_any  = 1'b1;
        fl_idx  = fl_idx | IDX_W'(i);
        fl_page = fl_page | st[i].page;
      end
      any_dirty = any_dirty | (st[i].valid & st[i].dirty);
      young_any = young_any | st[i].younger_dirty;
    end
  end

  // clamp the capacity register into the table size
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > CAPACITY) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign exec_go  = (state_r == ST_EXEC) && out_free;
  assign flush_go = (state_r == ST_FLUSH) && out_free;
  assign is_acc   = (req_op_r == OP_READ) || (req_op_r == OP_WRITE);

  // broadcast action
  always_comb begin
    cmd           = '0;
    cmd.page      = req_page_r;
    cmd.wr        = (req_op_r == OP_WRITE);
    cmd.touch     = exec_go && is_acc && hit_any;
    cmd.load      = exec_go && is_acc && !hit_any;
    cmd.evict     = cmd.load && (count_r >= cap_eff);
    cmd.discard   = exec_go && (req_op_r == OP_DISCARD) && hit_any;
    cmd.clean_hit = exec_go && (req_op_r == OP_FLUSH_PAGE) && hit_any;
    cmd.flush     = flush_go;
    cmd.hit_age   = hit_rec;
    cmd.evict_age = AGE_W'(count_r - 1'b1);
    cmd.flush_age = age_r;
  end

  // result word, count and sequencing
  always_comb begin
    res       = '0;
    emit      = 1'b0;
    count_nxt = count_r;
    state_nxt = state_r;
    age_nxt   = age_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
          res.last  = 1'b1;
          if (is_acc) begin
            if (hit_any) begin
              res.present = 1'b1;
              res.slot    = SLOT_W'(hit_idx);
            end else begin
              res.page_loaded = 1'b1;
              res.slot        = SLOT_W'(tgt_idx);
              if (cmd.evict) begin
                res.evicted      = 1'b1;
                res.evicted_page = ev_page;
                res.writeback    = ev_dirty;
                res.writeback_page = ev_dirty ? ev_page : '0;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
          end else if (req_op_r == OP_PROBE) begin
            res.present = hit_any;
            res.slot    = hit_any ? SLOT_W'(hit_idx) : '0;
          end else if (req_op_r == OP_DISCARD) begin
            if (hit_any) begin
              res.present        = 1'b1;
              res.evicted_page   = req_page_r;
              res.writeback      = hit_dirty;
              res.writeback_page = hit_dirty ? req_page_r : '0;
              count_nxt          = count_r - 1'b1;
            end
          end else if (req_op_r == OP_FLUSH_PAGE) begin
            if (hit_any) begin
              res.present        = 1'b1;
              res.slot           = SLOT_W'(hit_idx);
              res.writeback      = 1'b1;
              res.writeback_page = req_page_r;
            end
          end else if (req_op_r == OP_FLUSH_ALL) begin
            if (any_dirty) begin
              emit      = 1'b0;
              state_nxt = ST_FLUSH;
              age_nxt   = AGE_W'(CAPACITY - 1);
            end
          end
          res.loaded_count = LCNT_W'(count_nxt);
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          age_nxt = age_r - 1'b1;
          if (fl_any) begin
            emit               = 1'b1;
            res.present        = 1'b1;
            res.slot           = SLOT_W'(fl_idx);
            res.writeback      = 1'b1;
            res.writeback_page = fl_page;
            res.last           = !young_any;
            if (!young_any) begin
              state_nxt = ST_IDLE;
            end
          end
          res.loaded_count = LCNT_W'(count_r);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      age_r   <= age_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // capture request and result word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op_r <= in_word.op;
      if ((in_word.op == OP_READ) || (in_word.op == OP_WRITE)) begin
        req_page_r <= PAGE_W'(in_word.vaddr >> PAGE_SHIFT);
      end else begin
        req_page_r <= in_word.page_number;
      end
    end
    if (emit) begin
      out_word_r <= res;
    end
  end

endmodule

[hw/rtl/lpt_checker.sv]
module lpt_checker
  import lpt_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input lpt_out_t         out_word
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // residency never exceeds the table
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.loaded_count <= LCNT_W'(CAPACITY))
    else $error("loaded_count above table size");

  // a load comes from a missing access and ends its request
  a_load_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.page_loaded |-> !out_word.present && out_word.last)
    else $error("load word marked present or not last");

  // a write back on a load is the evicted page
  a_evict_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.page_loaded && out_word.writeback |->
      out_word.evicted && (out_word.writeback_page == out_word.evicted_page))
    else $error("load write back does not match eviction");

  // one request at a time: ready drops after a word is taken
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

endmodule

bind lru_page_table lpt_checker u_lpt_checker (.*);
